// ===== hdl/lbls_pkg.sv =====
// Shared types, widths, register codes and the square-root table for the
// log-bucket latency sketch. No dependencies.
`default_nettype none
package lbls_pkg;

  localparam int NUM_OPS_DEF  = 4;
  localparam int NUM_BINS_DEF = 256;

  localparam int LAT_W  = 48;
  localparam int CNT_W  = 16;
  localparam int Q_W    = 17;
  localparam int TOT_W  = 64;
  localparam int SAMP_W = 32;
  localparam int BCNT_W = 32;
  localparam int CFG_W  = 24;

  localparam logic [LAT_W-1:0] LAT_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [Q_W-1:0]   Q_ONE    = 17'h10000;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] CFG_INV_LOG2 = 2'd0;
  localparam logic [1:0] CFG_LOG2     = 2'd1;
  localparam logic [1:0] CFG_REP      = 2'd2;

  localparam logic [23:0] INV_LOG2_RST = 24'd476614;
  localparam logic [15:0] LOG2_RST     = 16'd9011;
  localparam logic [16:0] REP_RST      = 17'd62415;

  typedef struct packed {
    logic             action;
    logic [1:0]       op_id;
    logic [CNT_W-1:0] exec_count;
    logic [LAT_W-1:0] latency;
    logic [Q_W-1:0]   quantile_q16;
  } item_t;

  typedef logic [31:0] root_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int t = 0; t < 32; t++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int t = 0; t < 32; t++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Entry j holds 2^(2^-(j+1)) in Q30.
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int j = 0; j < 16; j++) begin
      root   = isqrt64(root << 30);
      tab[j] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage
`default_nettype wire

// ===== hdl/lbls_fifo.sv =====
// Two-entry request queue between the classifier and the histogram engine.
// Depends on nothing but its WIDTH parameter.
`default_nettype none
module lbls_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lbls_front.sv =====
// Request classifier: takes requests and computes the histogram bin of an
// add's latency (normalize, squaring log2, scale). Uses lbls_pkg.
`default_nettype none
module lbls_front
  import lbls_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int BW       = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             action,
  input  wire logic [1:0]       op_id,
  input  wire logic [CNT_W-1:0] exec_count,
  input  wire logic [LAT_W-1:0] latency,
  input  wire logic [Q_W-1:0]   quantile_q16,
  input  wire logic [23:0]      inv_log2_gamma,
  output logic                  push,
  output item_t                 push_item,
  output logic [BW-1:0]         push_bin,
  input  wire logic             full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_NORM = 3'd1;
  localparam logic [2:0] F_SQR  = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_BIN  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]       state;
  item_t            item;
  logic [LAT_W-1:0] nrm;
  logic [5:0]       shamt;
  logic [31:0]      x;
  logic [15:0]      frac;
  logic [3:0]       rnd;
  logic [45:0]      prod;
  logic [BW-1:0]    bin;

  logic [63:0] sq;
  logic [32:0] y;
  logic [5:0]  expo;
  logic [21:0] lval;
  logic [14:0] pos;
  logic [BW-1:0] bin_sat;

  assign sq      = 64'(x) * 64'(x);
  assign y       = sq[63:31];
  assign expo    = 6'd47 - shamt;
  assign lval    = {expo, frac};
  assign pos     = {1'b0, prod[45:32]} + 15'(|prod[31:0]);
  assign bin_sat = (pos > 15'(NUM_BINS - 1)) ? BW'(NUM_BINS - 1) : BW'(pos);

  assign in_stall  = state != F_IDLE;
  assign push      = (state == F_PUSH) && !full;
  assign push_item = item;
  assign push_bin  = bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            item  <= '{action, op_id, exec_count, latency, quantile_q16};
            nrm   <= latency;
            shamt <= '0;
            bin   <= '0;
            if (action == ACT_ADD && latency != '0) state <= F_NORM;
            else state <= F_PUSH;
          end
        end
        F_NORM: begin
          // Coarse byte steps first, then single bits, until bit 47 is set.
          if (nrm[47:40] == 8'd0) begin
            nrm   <= nrm << 8;
            shamt <= shamt + 6'd8;
          end else if (!nrm[47]) begin
            nrm   <= nrm << 1;
            shamt <= shamt + 6'd1;
          end else begin
            x     <= nrm[47:16];
            frac  <= '0;
            rnd   <= '0;
            state <= F_SQR;
          end
        end
        F_SQR: begin
          if (y[32]) begin
            x    <= y[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            x    <= y[31:0];
            frac <= {frac[14:0], 1'b0};
          end
          rnd <= rnd + 4'd1;
          if (rnd == 4'd15) state <= F_MUL;
        end
        F_MUL: begin
          prod  <= 46'(lval) * 46'(inv_log2_gamma);
          state <= F_BIN;
        end
        F_BIN: begin
          bin   <= bin_sat;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lbls_back.sv =====
// Histogram engine: per-operation statistics, bin memory with clearing
// pass, quantile walk and bin value rebuild. Uses lbls_pkg.
`default_nettype none
module lbls_back
  import lbls_pkg::*;
#(
  parameter int NUM_OPS  = NUM_OPS_DEF,
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int OPW      = 2,
  parameter int BW       = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  item_t                  q_item,
  input  wire logic [BW-1:0]     q_bin,
  output logic                   q_pop,
  input  wire logic [15:0]       log2_gamma,
  input  wire logic [16:0]       rep_scale,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   has_samples,
  output logic [LAT_W-1:0]       min_latency,
  output logic [LAT_W-1:0]       max_latency,
  output logic [LAT_W-1:0]       quantile_value,
  output logic [TOT_W-1:0]       total_executions,
  output logic [TOT_W-1:0]       total_time
);

  localparam int AW  = OPW + BW;
  localparam int SW  = BCNT_W + BW;
  localparam int EXW = BW + 16;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDWR = 4'd2;
  localparam logic [3:0] S_BOUND = 4'd3;
  localparam logic [3:0] S_WALK0 = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_POWE  = 4'd6;
  localparam logic [3:0] S_POWM  = 4'd7;
  localparam logic [3:0] S_POWP  = 4'd8;
  localparam logic [3:0] S_POWS  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]        state;
  logic [AW-1:0]     clr_addr;
  item_t             it;
  logic              ok;
  logic [BW-1:0]     bin;
  logic [LAT_W-1:0]  rmin [NUM_OPS];
  logic [LAT_W-1:0]  rmax [NUM_OPS];
  logic [SAMP_W-1:0] rsamp [NUM_OPS];
  logic [TOT_W-1:0]  gcount;
  logic [TOT_W-1:0]  gtime;
  logic [31:0]       bound;
  logic [BW-1:0]     idx;
  logic [SW-1:0]     sum;
  logic [EXW-1:0]    ex;
  logic [3:0]        step;
  logic [31:0]       m;
  logic [47:0]       p;
  logic [LAT_W-1:0]  qv;

  logic [BCNT_W-1:0] mem [2**AW];
  logic [BCNT_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [BCNT_W-1:0] wr_data;
  logic              mem_we;

  logic [OPW-1:0]    head_sel;
  logic              head_ok;
  logic [OPW-1:0]    it_sel;
  logic [SW-1:0]     sum_new;
  logic              walk_more;
  logic [47:0]       prod_b;
  logic [63:0]       prod_m;
  logic [15:0]       kk;
  logic [95:0]       wide;
  logic [LAT_W-1:0]  pow_v;
  logic              emit_go;

  assign head_sel = OPW'(q_item.op_id);
  assign head_ok  = 32'(q_item.op_id) < NUM_OPS;
  assign it_sel   = OPW'(it.op_id);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = {head_sel, q_bin};
      S_WALK0: rd_addr = {it_sel, BW'(0)};
      S_WALK:  rd_addr = {it_sel, idx + BW'(1)};
      default: rd_addr = {it_sel, bin};
    endcase
  end

  assign mem_we  = (state == S_CLEAR) || (state == S_ADDWR && ok);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : {it_sel, bin};
  assign wr_data = (state == S_CLEAR) ? '0 : rd_data + BCNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign sum_new   = sum + SW'(rd_data);
  assign walk_more = (idx != BW'(NUM_BINS - 1)) && (sum_new <= SW'(bound));
  assign prod_b    = 48'(it.quantile_q16[15:0]) * 48'(rsamp[it_sel] - SAMP_W'(1));
  assign prod_m    = 64'(m) * 64'(ROOT_TAB[step]);
  assign kk        = 16'(ex[EXW-1:16]);
  // Only used for k between 47 and 93, where k-46 fits in seven bits.
  assign wide      = {48'd0, p} << (kk[6:0] - 7'd46);

  // Scale by 2^(k-46) and saturate to 48 bits.
  always_comb begin
    if (kk <= 16'd46) begin
      pow_v = p >> (6'd46 - kk[5:0]);
    end else if (kk >= 16'd94) begin
      pow_v = (p != '0) ? LAT_ONES : '0;
    end else begin
      pow_v = (|wide[95:48]) ? LAT_ONES : wide[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      gcount   <= '0;
      gtime    <= '0;
      for (int o = 0; o < NUM_OPS; o++) begin
        rmin[o]  <= LAT_ONES;
        rmax[o]  <= '0;
        rsamp[o] <= '0;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            it  <= q_item;
            bin <= q_bin;
            ok  <= head_ok;
            qv  <= '0;
            if (q_item.action == ACT_ADD) begin
              gcount <= gcount + TOT_W'(q_item.exec_count);
              gtime  <= gtime + TOT_W'(q_item.latency);
              if (head_ok) begin
                if (q_item.latency < rmin[head_sel]) rmin[head_sel] <= q_item.latency;
                if (q_item.latency > rmax[head_sel]) rmax[head_sel] <= q_item.latency;
                rsamp[head_sel] <= rsamp[head_sel] + SAMP_W'(1);
              end
              state <= S_ADDWR;
            end else if (!head_ok) begin
              state <= S_EMIT;
            end else if (q_item.quantile_q16 == '0) begin
              qv    <= rmin[head_sel];
              state <= S_EMIT;
            end else if (q_item.quantile_q16 >= Q_ONE) begin
              qv    <= rmax[head_sel];
              state <= S_EMIT;
            end else begin
              state <= S_BOUND;
            end
          end
        end
        S_ADDWR: state <= S_EMIT;
        S_BOUND: begin
          bound <= (rsamp[it_sel] == '0) ? 32'd0 : prod_b[47:16];
          state <= S_WALK0;
        end
        S_WALK0: begin
          idx   <= '0;
          sum   <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (walk_more) begin
            idx <= idx + BW'(1);
            sum <= sum_new;
          end else begin
            state <= S_POWE;
          end
        end
        S_POWE: begin
          ex    <= EXW'(idx) * EXW'(log2_gamma);
          m     <= 32'd1 << 30;
          step  <= '0;
          state <= S_POWM;
        end
        S_POWM: begin
          if (ex[4'd15 - step]) m <= prod_m[61:30];
          step <= step + 4'd1;
          if (step == 4'd15) state <= S_POWP;
        end
        S_POWP: begin
          p     <= 48'(m) * 48'(rep_scale);
          state <= S_POWS;
        end
        S_POWS: begin
          qv    <= pow_v;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      has_samples      <= ok && (rsamp[it_sel] != '0);
      min_latency      <= ok ? rmin[it_sel] : LAT_ONES;
      max_latency      <= ok ? rmax[it_sel] : '0;
      quantile_value   <= qv;
      total_executions <= gcount;
      total_time       <= gtime;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_go) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

`ifndef ASSERT_OFF
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE)
    else $error("engine stayed idle after taking a request");
  a_addwr_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_ADDWR |-> $past(q_pop))
    else $error("bin update without a preceding request");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside the emit step");
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !q_pop && !out_valid)
    else $error("request handled during the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== hdl/log_bucket_latency_sketch.sv =====
// Top level of the log-bucket latency sketch: configuration registers,
// classifier, request queue and histogram engine. Uses lbls_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    action, op_id, exec_count, latency, quantile_q16
//   out      output     out_valid / out_stall  has_samples .. total_time
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// An add passes through the classifier as accept, normalize steps, 16 squaring
// rounds, scale, saturate and push, then through the bin update in the engine;
// a query with a quantile strictly between 0 and 1 walks up to NUM_BINS bins
// in the engine over one memory port.
// After reset the engine clears the bin memory, one entry per cycle
// (2^(OPW+BW) entries, 1024 by default); requests queue up meanwhile.
// A stalled result holds; the classifier keeps working into the queue.
`default_nettype none
module log_bucket_latency_sketch
  import lbls_pkg::*;
#(
  parameter int NUM_OPS  = NUM_OPS_DEF,
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic [1:0]        op_id,
  input  wire logic [CNT_W-1:0]  exec_count,
  input  wire logic [LAT_W-1:0]  latency,
  input  wire logic [Q_W-1:0]    quantile_q16,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   has_samples,
  output logic [LAT_W-1:0]       min_latency,
  output logic [LAT_W-1:0]       max_latency,
  output logic [LAT_W-1:0]       quantile_value,
  output logic [TOT_W-1:0]       total_executions,
  output logic [TOT_W-1:0]       total_time,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int OPW = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
  localparam int BW  = $clog2(NUM_BINS);
  localparam int QW  = $bits(item_t) + BW;

  logic [23:0] inv_log2_gamma;
  logic [15:0] log2_gamma;
  logic [16:0] rep_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_log2_gamma <= INV_LOG2_RST;
      log2_gamma     <= LOG2_RST;
      rep_scale      <= REP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_LOG2: inv_log2_gamma <= cfg_data;
        CFG_LOG2:     log2_gamma     <= cfg_data[15:0];
        CFG_REP:      rep_scale      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic          push;
  item_t         push_item;
  logic [BW-1:0] push_bin;
  logic          full;
  logic          pop;
  logic          empty;
  logic [QW-1:0] pop_data;
  item_t         q_item;
  logic [BW-1:0] q_bin;

  assign q_item = pop_data[QW-1:BW];
  assign q_bin  = pop_data[BW-1:0];

  lbls_front #(
    .NUM_BINS(NUM_BINS),
    .BW(BW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .op_id(op_id),
    .exec_count(exec_count),
    .latency(latency),
    .quantile_q16(quantile_q16),
    .inv_log2_gamma(inv_log2_gamma),
    .push(push),
    .push_item(push_item),
    .push_bin(push_bin),
    .full(full)
  );

  lbls_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_item, push_bin}),
    .full(full),
    .pop(pop),
    .pop_data(pop_data),
    .empty(empty)
  );

  lbls_back #(
    .NUM_OPS(NUM_OPS),
    .NUM_BINS(NUM_BINS),
    .OPW(OPW),
    .BW(BW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(empty),
    .q_item(q_item),
    .q_bin(q_bin),
    .q_pop(pop),
    .log2_gamma(log2_gamma),
    .rep_scale(rep_scale),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .has_samples(has_samples),
    .min_latency(min_latency),
    .max_latency(max_latency),
    .quantile_value(quantile_value),
    .total_executions(total_executions),
    .total_time(total_time)
  );

endmodule
`default_nettype wire
